@@ src/convex_polygon_span_table_core_assert.svh @@
// ----------------------------------------------------------------------------
// convex_polygon_span_table_core_assert.svh
// Assertion macros used by the span table core RTL.
// ----------------------------------------------------------------------------
`ifndef CONVEX_POLYGON_SPAN_TABLE_CORE_ASSERT_SVH
`define CONVEX_POLYGON_SPAN_TABLE_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CPST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define CPST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/cpst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpst_pkg
// Shared types and constants for the convex polygon span table.
// ----------------------------------------------------------------------------
package cpst_pkg;

	localparam int COORD_W               = 12;
	localparam int ROW_IN_W              = 10;
	localparam int ROWS_DEFAULT          = 1024;
	localparam int FRACTION_BITS_DEFAULT = 16;

	// empty-row sentinels
	localparam logic signed [COORD_W-1:0] EMPTY_LEFT  = 12'sh7FF;
	localparam logic signed [COORD_W-1:0] EMPTY_RIGHT = 12'sh800;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_VERTEX = 2'd1,
		KIND_READ   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		TBL_NOP    = 2'd0,
		TBL_CLEAR  = 2'd1,
		TBL_UPDATE = 2'd2,
		TBL_READ   = 2'd3
	} tbl_op_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic                      first_vertex;
		logic                      last_vertex;
		logic [ROW_IN_W-1:0]       row;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] span_left;
		logic signed [COORD_W-1:0] span_right;
		logic                      span_filled;
	} result_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] right;
	} span_t;

endpackage

@@ src/cpst_slope_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpst_slope_div
// Restoring divider, one quotient bit per cycle: (dx << F) / dy toward zero.
// ----------------------------------------------------------------------------
module cpst_slope_div import cpst_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
	localparam int NW = COORD_W + FRACTION_BITS,
	localparam int SW = NW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [COORD_W:0] dx,
	input  logic [COORD_W-1:0]   dy,
	output logic                 done,
	output logic signed [SW-1:0] slope
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [COORD_W-1:0] rem_q;
	logic [COORD_W-1:0] dy_q;
	logic [NW-1:0] nq_q;
	logic          neg_q;

	logic [COORD_W:0] abs_dx;
	logic [COORD_W:0] trial;
	logic [COORD_W:0] diff;
	logic             fits;

	assign abs_dx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
	assign trial  = {rem_q, nq_q[NW-1]};
	assign diff   = trial - {1'b0, dy_q};
	assign fits   = trial >= {1'b0, dy_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nq_q  <= {abs_dx[COORD_W-1:0], {FRACTION_BITS{1'b0}}};
			dy_q  <= dy;
			neg_q <= dx[COORD_W];
		end else if (busy_q) begin
			rem_q <= fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
			nq_q  <= {nq_q[NW-2:0], fits};
		end
	end

	assign done  = done_q;
	assign slope = neg_q ? -$signed({1'b0, nq_q}) : $signed({1'b0, nq_q});

endmodule

@@ src/cpst_span_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpst_span_table
// Row span memory: clear writes, registered reads, read-modify-write updates.
// ----------------------------------------------------------------------------
module cpst_span_table import cpst_pkg::*; #(
	parameter int ROWS          = ROWS_DEFAULT,
	parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
	localparam int ROW_W = $clog2(ROWS),
	localparam int XW    = COORD_W + 1 + FRACTION_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tbl_op_t              op,
	input  logic [ROW_W-1:0]     addr,
	input  logic signed [XW-1:0] x,
	output span_t                rd_span,
	output logic                 busy
);

	localparam logic [XW-1:0] FRAC_ONES =
		{{(COORD_W+1){1'b0}}, {FRACTION_BITS{1'b1}}};

	span_t            span_mem_q [ROWS];
	span_t            rdata_q;
	logic             upd_s1;
	logic [ROW_W-1:0] addr_s1;
	logic signed [XW-1:0] x_s1;

	logic signed [XW-1:0] l_fx;
	logic signed [XW-1:0] r_fx;
	logic signed [XW-1:0] ceil_sum;
	span_t                new_span;

	// bounds in fixed point, then ceil for left and floor for right
	always_comb begin
		l_fx     = $signed({rdata_q.left[COORD_W-1], rdata_q.left,
			{FRACTION_BITS{1'b0}}});
		r_fx     = $signed({rdata_q.right[COORD_W-1], rdata_q.right,
			{FRACTION_BITS{1'b0}}});
		ceil_sum = x_s1 + $signed(FRAC_ONES);
		new_span = rdata_q;
		if (x_s1 < l_fx)
			new_span.left = ceil_sum[FRACTION_BITS +: COORD_W];
		if (x_s1 > r_fx)
			new_span.right = x_s1[FRACTION_BITS +: COORD_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1 <= 1'b0;
		end else begin
			upd_s1 <= (op == TBL_UPDATE);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		x_s1    <= x;
	end

	always_ff @(posedge clk) begin
		if (upd_s1) begin
			span_mem_q[addr_s1] <= new_span;
		end else if (op == TBL_CLEAR) begin
			span_mem_q[addr] <= '{left: EMPTY_LEFT, right: EMPTY_RIGHT};
		end
		if (op == TBL_UPDATE || op == TBL_READ) begin
			rdata_q <= span_mem_q[addr];
		end
	end

	assign rd_span = rdata_q;
	assign busy    = upd_s1;

endmodule

@@ src/convex_polygon_span_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_polygon_span_table_core
// Scan-line edge table for convex polygon fill: per-row left/right bounds.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload    carries
//  item      item_valid / item_stall     item_t     clear, vertex or row read
//  result    result_valid / result_stall result_t   span of one row (reads)
//
//  Clear: one row written per cycle by a sweep counter.
//  Vertex: per non-horizontal edge, a setup state, the serial slope divider, then
//    a walk over the spanned rows; a vertex closes the edge from the previous
//    vertex and, if last, the edge to the first; horizontal edges skip divider and walk.
//  Read: bound by the registered read port of the table memory.
//  Reset starts the same clearing pass; item_stall stays high.
//  item_stall is high whenever an earlier transaction is still at work;
//    a read result waits in the output register while result_stall is high.
// ----------------------------------------------------------------------------
`include "convex_polygon_span_table_core_assert.svh"

module convex_polygon_span_table_core import cpst_pkg::*; #(
	parameter int ROWS          = ROWS_DEFAULT,
	parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int ROW_W = $clog2(ROWS);
	localparam int XW    = COORD_W + 1 + FRACTION_BITS;
	localparam logic [COORD_W:0] ROWS_LIM = (COORD_W+1)'(ROWS);

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CLEAR = 6'b000010,
		ST_EDGE  = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_WALK  = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	state_t state_q;

	// polygon state
	logic signed [COORD_W-1:0] first_x_q, first_y_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q;

	// edges still to walk: A = previous -> current, B = current -> first
	logic                      edge_a_q, edge_b_q;
	logic signed [COORD_W-1:0] a_x_q, a_y_q, v_x_q, v_y_q;

	// walker
	logic signed [XW-1:0]      x_acc_q;
	logic signed [XW-1:0]      slope_q;
	logic signed [COORD_W-1:0] walk_y_q;
	logic [COORD_W-1:0]        rows_left_q;

	logic [ROW_W-1:0] clr_q;
	logic             clr_last;
	logic             rd_oob_q;
	logic             result_valid_q;
	result_t          result_q;

	logic item_take;

	// edge set-up
	logic signed [COORD_W-1:0] sel_x0, sel_y0, sel_x1, sel_y1;
	logic signed [COORD_W-1:0] lo_x, lo_y, hi_x, hi_y;
	logic                      swap, edge_any, flat;
	logic signed [COORD_W:0]   dx;
	logic [COORD_W:0]          dy_full;
	logic                      div_start, div_done;
	logic signed [XW-1:0]      div_slope;

	// table port
	tbl_op_t          tbl_op;
	logic [ROW_W-1:0] tbl_addr;
	span_t            tbl_span;
	logic             tbl_busy;

	logic [COORD_W-1:0] row_ext;
	logic               row_in_range;
	logic               walk_in_range;
	logic               resp_go;

	assign item_take = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign clr_last  = (clr_q == ROW_W'(ROWS - 1));
	assign resp_go   = (state_q == ST_RESP) && (!result_valid_q || !result_stall);

	assign row_ext       = {{(COORD_W-ROW_IN_W){1'b0}}, item.row};
	assign row_in_range  = ({1'b0, row_ext} < ROWS_LIM);
	assign walk_in_range = !walk_y_q[COORD_W-1] && ({1'b0, walk_y_q} < ROWS_LIM);

	// pick the pending edge and order its ends by y
	always_comb begin
		edge_any = edge_a_q || edge_b_q;
		sel_x0   = edge_a_q ? a_x_q : v_x_q;
		sel_y0   = edge_a_q ? a_y_q : v_y_q;
		sel_x1   = edge_a_q ? v_x_q : first_x_q;
		sel_y1   = edge_a_q ? v_y_q : first_y_q;
		swap     = sel_y0 > sel_y1;
		flat     = sel_y0 == sel_y1;
		lo_x     = swap ? sel_x1 : sel_x0;
		lo_y     = swap ? sel_y1 : sel_y0;
		hi_x     = swap ? sel_x0 : sel_x1;
		hi_y     = swap ? sel_y0 : sel_y1;
		dx       = {hi_x[COORD_W-1], hi_x} - {lo_x[COORD_W-1], lo_x};
		dy_full  = {hi_y[COORD_W-1], hi_y} - {lo_y[COORD_W-1], lo_y};
		div_start = (state_q == ST_EDGE) && edge_any && !flat;
	end

	// table access per state
	always_comb begin
		tbl_op   = TBL_NOP;
		tbl_addr = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_take && item.kind == KIND_READ) begin
					tbl_op   = TBL_READ;
					tbl_addr = row_ext[ROW_W-1:0];
				end
			end
			ST_CLEAR: begin
				tbl_op   = TBL_CLEAR;
				tbl_addr = clr_q;
			end
			ST_WALK: begin
				tbl_op   = walk_in_range ? TBL_UPDATE : TBL_NOP;
				tbl_addr = walk_y_q[ROW_W-1:0];
			end
			default: begin
				tbl_op   = TBL_NOP;
				tbl_addr = '0;
			end
		endcase
	end

	cpst_slope_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.dx    (dx),
		.dy    (dy_full[COORD_W-1:0]),
		.done  (div_done),
		.slope (div_slope)
	);

	cpst_span_table #(
		.ROWS         (ROWS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (tbl_op),
		.addr   (tbl_addr),
		.x      (x_acc_q),
		.rd_span(tbl_span),
		.busy   (tbl_busy)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			edge_a_q       <= 1'b0;
			edge_b_q       <= 1'b0;
			first_x_q      <= '0;
			first_y_q      <= '0;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			rd_oob_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// a fresh result reloads the register in the same cycle
			if (result_valid_q && !result_stall && !resp_go)
				result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_take) begin
						case (item.kind)
							KIND_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							KIND_VERTEX: begin
								if (item.first_vertex) begin
									first_x_q <= item.vertex_x;
									first_y_q <= item.vertex_y;
								end
								edge_a_q <= !item.first_vertex;
								edge_b_q <= item.last_vertex;
								prev_x_q <= item.vertex_x;
								prev_y_q <= item.vertex_y;
								state_q  <= ST_EDGE;
							end
							KIND_READ: begin
								rd_oob_q <= !row_in_range;
								state_q  <= ST_RESP;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last)
						state_q <= ST_IDLE;
				end
				ST_EDGE: begin
					if (!edge_any) begin
						state_q <= ST_IDLE;
					end else begin
						if (edge_a_q)
							edge_a_q <= 1'b0;
						else
							edge_b_q <= 1'b0;
						if (!flat)
							state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (rows_left_q == COORD_W'(1))
						state_q <= ST_EDGE;
				end
				ST_RESP: begin
					if (resp_go) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_take && item.kind == KIND_VERTEX) begin
			a_x_q <= prev_x_q;
			a_y_q <= prev_y_q;
			v_x_q <= item.vertex_x;
			v_y_q <= item.vertex_y;
		end
		if (div_start) begin
			x_acc_q     <= $signed({lo_x[COORD_W-1], lo_x, {FRACTION_BITS{1'b0}}});
			walk_y_q    <= lo_y;
			rows_left_q <= dy_full[COORD_W-1:0];
		end else if (state_q == ST_WALK) begin
			x_acc_q     <= x_acc_q + slope_q;
			walk_y_q    <= walk_y_q + 1'b1;
			rows_left_q <= rows_left_q - 1'b1;
		end
		if (state_q == ST_DIV && div_done)
			slope_q <= div_slope;
		if (resp_go) begin
			if (rd_oob_q) begin
				result_q.span_left   <= EMPTY_LEFT;
				result_q.span_right  <= EMPTY_RIGHT;
				result_q.span_filled <= 1'b0;
			end else begin
				result_q.span_left   <= tbl_span.left;
				result_q.span_right  <= tbl_span.right;
				result_q.span_filled <= tbl_span.left < tbl_span.right;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a new transaction never meets a row write still in flight
	`CPST_ASSERT_NOW(a_take_tbl_quiet, clk, arst_n, item_take, !tbl_busy, "item taken during row write")
	// slope arrives only while the sequencer waits for it
	`CPST_ASSERT_NOW(a_div_done_state, clk, arst_n, div_done, state_q == ST_DIV, "stray divider done")
	// a pending read result is loaded once the output register is free
	`CPST_ASSERT_NEXT(a_resp_loads, clk, arst_n, resp_go, result_valid_q && state_q == ST_IDLE, "read result not loaded")
	// the clearing sweep ends after its last row
	`CPST_ASSERT_NEXT(a_clear_ends, clk, arst_n, state_q == ST_CLEAR && clr_last, state_q == ST_IDLE, "clear sweep overran")

endmodule
